// ===== sv/lzss_stream_decoder_assert.svh =====
// Assertion macros for the LZSS stream decoder.
// Used by the top level; no other dependencies.
`ifndef LZSS_STREAM_DECODER_ASSERT_SVH
`define LZSS_STREAM_DECODER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define LZSSD_ASSERT_NOW(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("lzssd assertion failed");
// next-cycle implication
`define LZSSD_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("lzssd assertion failed");
`else
`define LZSSD_ASSERT_NOW(label, clk, rst_n, a, c)
`define LZSSD_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif

`endif

// ===== sv/lzssd_pkg.sv =====
// Shared types and constants of the LZSS stream decoder.
// No dependencies; imported by the control, output and top modules.
package lzssd_pkg;

	localparam logic [15:0] RESET_OUTPUT_SIZE = 16'd1680;
	localparam logic [3:0]  FLAGS_PER_BYTE    = 4'd8;
	localparam logic [5:0]  LEN_BIAS          = 6'd3;
	localparam logic [11:0] OFFSET_BIAS       = 12'd1;

	// token parser and copy sequencer
	typedef enum logic [1:0] {
		ST_FLAG,
		ST_TOKEN,
		ST_MATCH2,
		ST_COPY
	} fsm_state_t;

	// where the byte held in the issue stage comes from
	typedef enum logic [1:0] {
		SRC_LIT,
		SRC_MEM,
		SRC_FWD,
		SRC_ZERO
	} byte_src_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       new_stream;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       stream_done;
		logic       bad_offset;
	} out_item_t;

endpackage

// ===== sv/lzss_stream_decoder.sv =====
// Channel | Dir | Payload                       | Handshake
// cfg     | in  | output_size, 16 bits          | cfg_valid / cfg_ready
// in      | in  | in_item_t: in_byte, new_stream | in_valid / in_ready
// out     | out | out_item_t: out_byte, flags    | out_valid / out_ready
//
// A flag byte or first match byte only updates the token state; a literal passes
// through the issue stage into the output register, and the next request waits
// for the issue stage to empty. A match of n bytes issues one history read per
// cycle while the issue stage is free, and the next request is taken once the copy
// is done and the issue stage is empty; the single read port of the history memory sets that pace.
// Reset clears counters and token state at once; history is not cleared, and
// reads ahead of the bytes produced are flagged as bad offsets.
// A stalled output holds the issue stage, which in turn holds the copy.
//
// Top level of the LZSS stream decoder.
// Depends on lzssd_pkg, lzssd_hist_ram, lzssd_out_reg, lzssd_ctrl and the assert header.
`include "lzss_stream_decoder_assert.svh"

module lzss_stream_decoder #(
	parameter int HISTORY_DEPTH = 2048
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [15:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lzssd_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lzssd_pkg::out_item_t out_data
);
	import lzssd_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);

	logic          item_valid;
	logic          item_ready;
	out_item_t     item;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;

	// parser and copy sequencer
	lzssd_ctrl #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	// output history
	lzssd_hist_ram #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// result register
	lzssd_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	// a request is only taken with the issue stage empty
	`LZSSD_ASSERT_NOW(a_ready_stage_empty, clk, arst_n, in_ready, !item_valid)
	// flagged bytes are given as zero
	`LZSSD_ASSERT_NOW(a_bad_is_zero, clk, arst_n, out_valid && out_data.bad_offset, out_data.out_byte == 8'd0)
	// the byte that ends a stream also ends its run
	`LZSSD_ASSERT_NOW(a_done_is_last, clk, arst_n, out_valid && out_data.stream_done, out_data.last_of_run)
	// a held result stays put until taken
	`LZSSD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

// ===== sv/lzssd_hist_ram.sv =====
// History memory: one write port, one registered read port with enable.
// No dependencies.
module lzssd_hist_ram #(
	parameter int HISTORY_DEPTH = 2048
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(HISTORY_DEPTH)-1:0] waddr,
	input  logic [7:0]                       wdata,
	input  logic                             re,
	input  logic [$clog2(HISTORY_DEPTH)-1:0] raddr,
	output logic [7:0]                       rdata
);

	logic [7:0] mem [HISTORY_DEPTH];
	logic [7:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port; data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/lzssd_out_reg.sv =====
// Output register between the issue stage and the result channel.
// Depends on lzssd_pkg.
module lzssd_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  lzssd_pkg::out_item_t item,
	output logic                 item_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lzssd_pkg::out_item_t out_data
);
	import lzssd_pkg::*;

	logic      out_valid_q;
	out_item_t out_data_q;

	// free when empty or being emptied this cycle
	assign item_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_ready) begin
			out_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			out_data_q <= item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== sv/lzssd_ctrl.sv =====
// Token parser, match copy sequencer and issue stage of the decoder.
// Depends on lzssd_pkg; drives the history memory ports.
module lzssd_ctrl #(
	parameter int HISTORY_DEPTH = 2048
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [15:0]                      cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  lzssd_pkg::in_item_t              in_data,
	output logic                             item_valid,
	output lzssd_pkg::out_item_t             item,
	input  logic                             item_ready,
	output logic                             mem_we,
	output logic [$clog2(HISTORY_DEPTH)-1:0] mem_waddr,
	output logic [7:0]                       mem_wdata,
	output logic                             mem_re,
	output logic [$clog2(HISTORY_DEPTH)-1:0] mem_raddr,
	input  logic [7:0]                       mem_rdata
);
	import lzssd_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam logic [AW:0]   DEPTH_W   = (AW+1)'(HISTORY_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);

	// stream and token state
	fsm_state_t  state_q, state_d;
	logic [15:0] size_q;
	logic [15:0] produced_q;
	logic [AW-1:0] wr_ptr_q;
	logic [7:0]  flag_q;
	logic [3:0]  flags_left_q;
	logic [7:0]  off_low_q;
	logic [7:0]  last_byte_q;

	// copy sequencer
	logic [5:0]    rem_q;
	logic [11:0]   off_q;
	logic [AW-1:0] rd_ptr_q;

	// issue stage
	logic      s1_valid_s1;
	byte_src_t s1_src_s1;
	logic [7:0] s1_lit_s1;
	logic      s1_last_s1;
	logic      s1_done_s1;
	logic      s1_bad_s1;

	logic        in_fire;
	fsm_state_t  eff_state;
	logic [15:0] eff_prod;
	logic        stream_ended;
	logic        issue_ok;
	logic        s1_adv;
	logic        copy_issue;
	logic        lit_take;
	logic        copy_last;
	logic        copy_bad;
	logic [15:0] prod_next;
	logic [11:0] match_off;
	logic [5:0]  match_len;
	logic [AW:0] rd_diff;
	logic [AW-1:0] rd_start;
	logic [7:0]  s1_byte;

	assign cfg_ready = 1'b1;

	// view of the state once a new_stream mark has been applied
	assign in_fire      = in_valid && in_ready;
	assign eff_state    = in_data.new_stream ? ST_FLAG : state_q;
	assign eff_prod     = in_data.new_stream ? 16'd0 : produced_q;
	assign stream_ended = eff_prod >= size_q;
	assign prod_next    = produced_q + 16'd1;

	// match decode and history start address (wraps at the memory depth)
	assign match_off = {1'b0, in_data.in_byte[7:5], off_low_q} + OFFSET_BIAS;
	assign match_len = {1'b0, in_data.in_byte[4:0]} + LEN_BIAS;
	assign rd_diff   = {1'b0, wr_ptr_q} - (AW+1)'(match_off);
	assign rd_start  = rd_diff[AW] ? AW'(rd_diff + DEPTH_W) : rd_diff[AW-1:0];

	// copy byte attributes
	assign copy_last = (rem_q == 6'd1) || (prod_next == size_q);
	assign copy_bad  = 16'(off_q) > produced_q;

	// handshake and issue control
	always_comb begin
		issue_ok   = !s1_valid_s1 || item_ready;
		s1_adv     = s1_valid_s1 && item_ready;
		in_ready   = (state_q != ST_COPY) && !s1_valid_s1;
		copy_issue = (state_q == ST_COPY) && issue_ok;
		lit_take   = in_fire && !stream_ended && (eff_state == ST_TOKEN) && flag_q[0];
		mem_re     = copy_issue;
		mem_raddr  = rd_ptr_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		if (in_fire) begin
			if (stream_ended) begin
				state_d = eff_state;
			end else begin
				case (eff_state)
					ST_FLAG:   state_d = ST_TOKEN;
					ST_TOKEN: begin
						if (flag_q[0]) begin
							state_d = (flags_left_q == 4'd1) ? ST_FLAG : ST_TOKEN;
						end else begin
							state_d = ST_MATCH2;
						end
					end
					ST_MATCH2: state_d = ST_COPY;
					default:   state_d = state_q;
				endcase
			end
		end else if (copy_issue && copy_last) begin
			state_d = (flags_left_q == 4'd0) ? ST_FLAG : ST_TOKEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FLAG;
		end else begin
			state_q <= state_d;
		end
	end

	// stream counters, token registers and copy sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q       <= RESET_OUTPUT_SIZE;
			produced_q   <= 16'd0;
			wr_ptr_q     <= '0;
			flag_q       <= 8'd0;
			flags_left_q <= 4'd0;
			off_low_q    <= 8'd0;
			rem_q        <= 6'd0;
			off_q        <= 12'd0;
			rd_ptr_q     <= '0;
		end else begin
			if (cfg_valid) begin
				size_q <= cfg_data;
			end
			if (in_fire) begin
				if (in_data.new_stream) begin
					produced_q <= 16'd0;
					wr_ptr_q   <= '0;
					off_low_q  <= 8'd0;
				end
				if (stream_ended) begin
					// stream restarted but already complete: token state cleared
					if (in_data.new_stream) begin
						flag_q       <= 8'd0;
						flags_left_q <= 4'd0;
					end
				end else begin
					case (eff_state)
						ST_FLAG: begin
							flag_q       <= in_data.in_byte;
							flags_left_q <= FLAGS_PER_BYTE;
						end
						ST_TOKEN: begin
							if (flag_q[0]) begin
								produced_q   <= prod_next;
								flag_q       <= {1'b0, flag_q[7:1]};
								flags_left_q <= flags_left_q - 4'd1;
							end else begin
								off_low_q <= in_data.in_byte;
							end
						end
						ST_MATCH2: begin
							off_q        <= match_off;
							rem_q        <= match_len;
							rd_ptr_q     <= rd_start;
							flag_q       <= {1'b0, flag_q[7:1]};
							flags_left_q <= flags_left_q - 4'd1;
						end
						default: begin
							flag_q <= flag_q;
						end
					endcase
				end
			end
			if (copy_issue) begin
				produced_q <= prod_next;
				rem_q      <= rem_q - 6'd1;
				rd_ptr_q   <= (rd_ptr_q == LAST_ADDR) ? '0 : rd_ptr_q + 1'b1;
			end
			// history write pointer follows the bytes leaving the issue stage
			if (s1_adv) begin
				wr_ptr_q <= (wr_ptr_q == LAST_ADDR) ? '0 : wr_ptr_q + 1'b1;
			end
		end
	end

	// issue stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (lit_take || copy_issue) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	// issue stage payload
	always_ff @(posedge clk) begin
		if (lit_take) begin
			s1_src_s1  <= SRC_LIT;
			s1_lit_s1  <= in_data.in_byte;
			s1_last_s1 <= 1'b1;
			s1_done_s1 <= prod_next == size_q;
			s1_bad_s1  <= 1'b0;
		end else if (copy_issue) begin
			// offset of one reads the byte still being written: forward it
			if (copy_bad) begin
				s1_src_s1 <= SRC_ZERO;
			end else if (off_q == OFFSET_BIAS) begin
				s1_src_s1 <= SRC_FWD;
			end else begin
				s1_src_s1 <= SRC_MEM;
			end
			s1_lit_s1  <= 8'd0;
			s1_last_s1 <= copy_last;
			s1_done_s1 <= prod_next == size_q;
			s1_bad_s1  <= copy_bad;
		end
	end

	// last byte put, for the forwarding path
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			last_byte_q <= s1_byte;
		end
	end

	// resolve the byte of the issue stage
	always_comb begin
		case (s1_src_s1)
			SRC_LIT:  s1_byte = s1_lit_s1;
			SRC_MEM:  s1_byte = mem_rdata;
			SRC_FWD:  s1_byte = last_byte_q;
			SRC_ZERO: s1_byte = 8'd0;
			default:  s1_byte = 8'd0;
		endcase
	end

	assign item_valid       = s1_valid_s1;
	assign item.out_byte    = s1_byte;
	assign item.last_of_run = s1_last_s1;
	assign item.stream_done = s1_done_s1;
	assign item.bad_offset  = s1_bad_s1;

	assign mem_we    = s1_adv;
	assign mem_waddr = wr_ptr_q;
	assign mem_wdata = s1_byte;

endmodule
